// ----- sv/flsh_pkg.sv -----
// ----------------------------------------------------------------------------
// flsh_pkg: four-lane stripe hash shared definitions
// Constants, sequencer states, multiplier request type and small helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package flsh_pkg;

  localparam logic [63:0] P1 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] P2 = 64'h14DEF9DEA2F79CD6;
  localparam logic [63:0] P3 = 64'h165667B19E3779F9;
  localparam logic [63:0] P4 = 64'h85EBCA77C2B2ED6B;
  localparam logic [63:0] P5 = 64'h27D4EB2F165667C5;

  // lane seeds
  localparam logic [63:0] SEED0 = P5 + 64'd8;
  localparam logic [63:0] SEED1 = P4;
  localparam logic [63:0] SEED2 = 64'd0;
  localparam logic [63:0] SEED3 = P1;

  localparam int unsigned ROUND_SHIFT = 31;
  localparam int unsigned MIX0_SHIFT  = 33;
  localparam int unsigned MIX1_SHIFT  = 29;
  localparam int unsigned MIX2_SHIFT  = 32;

  localparam logic [1:0] MIX_FIRST = 2'd0;
  localparam logic [1:0] MIX_LAST  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_W_START,
    ST_W_WAIT,
    ST_V_START,
    ST_V_WAIT,
    ST_COMBINE,
    ST_MIX_START,
    ST_MIX_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  // zero the bytes above the count, count above eight keeps all
  function automatic logic [63:0] mask_word(input logic [63:0] w, input logic [3:0] cnt);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < cnt) begin
        r[8*i +: 8] = w[8*i +: 8];
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] mix_operand(input logic [63:0] h, input logic [63:0] v,
                                              input logic [1:0] idx);
    logic [63:0] r;
    unique case (idx)
      2'd0:    r = h ^ (v >> MIX0_SHIFT);
      2'd1:    r = h ^ (v >> MIX1_SHIFT);
      default: r = h ^ (v >> MIX2_SHIFT);
    endcase
    return r;
  endfunction

  function automatic logic [63:0] mix_mult(input logic [1:0] idx);
    logic [63:0] r;
    unique case (idx)
      2'd0:    r = P2;
      2'd1:    r = P3;
      default: r = P4;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] mix_add(input logic [1:0] idx);
    logic [63:0] r;
    unique case (idx)
      2'd0:    r = P3;
      2'd1:    r = P4;
      default: r = P5;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/flsh_if.sv -----
// ----------------------------------------------------------------------------
// flsh_if: stream channels of the stripe hash
// Message word channel and hash result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface flsh_word_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        last_word;

  modport source (output valid, output data_word, output byte_count, output last_word,
                  input ready);
  modport sink   (input valid, input data_word, input byte_count, input last_word,
                  output ready);
endinterface

interface flsh_hash_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

`default_nettype wire

// ----- sv/flsh_mul64.sv -----
// ----------------------------------------------------------------------------
// flsh_mul64: iterative 64x64 multiplier, low 64 bits of the product
// One 32x32 multiplier used in three passes: lo*lo, then both cross terms.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module flsh_mul64 (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire flsh_pkg::mul_req_t req,
  output logic                   done,
  output logic [63:0]            product
);

  logic [63:0] a;
  logic [63:0] b;
  logic [1:0]  step;
  logic        busy;
  logic [31:0] op_x;
  logic [31:0] op_y;
  logic [63:0] pp;

  always_comb begin
    unique case (step)
      2'd0: begin
        op_x = a[31:0];
        op_y = b[31:0];
      end
      2'd1: begin
        op_x = a[31:0];
        op_y = b[63:32];
      end
      default: begin
        op_x = a[63:32];
        op_y = b[31:0];
      end
    endcase
  end

  assign pp = op_x * op_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        a    <= req.a;
        b    <= req.b;
        step <= 2'd0;
        busy <= 1'b1;
      end else if (busy) begin
        // cross terms only reach the upper half
        if (step == 2'd0) begin
          product <= pp;
        end else begin
          product <= product + {pp[31:0], 32'd0};
        end
        if (step == 2'd2) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/four_lane_stripe_hash64_core.sv -----
// ----------------------------------------------------------------------------
// four_lane_stripe_hash64_core: four-lane 64-bit stripe hash
// Absorbs message words into four lane accumulators and emits the mixed hash.
// ----------------------------------------------------------------------------
// channel   dir  payload                               request
// message   in   data_word[63:0] byte_count[3:0]       one message word
//                last_word
// digest    out  hash_value[63:0]                      one hash per message
//
// a word holds message low while it is in work: two 64-bit multiplies, each a start
// state and a wait state (three passes of the shared 32x32 multiplier and
// the done hand-off), so a new word is taken only once the last one is through
// the last word adds zero rounds until the stripe closes, a combine step,
// three mixes of a start and a wait state each, and the emit step
// message is not ready while a word is in work; a stalled digest holds the
// final step until taken. synchronous reset reseeds the lanes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module four_lane_stripe_hash64_core (
  input  wire logic   clk,
  input  wire logic   rst,
  flsh_word_if.sink   message,
  flsh_hash_if.source digest
);

  flsh_pkg::state_t   state;
  flsh_pkg::state_t   state_next;
  flsh_pkg::mul_req_t mul_req;

  logic [63:0] lane_acc [4];
  logic [1:0]  lane_pos;
  logic [1:0]  lane_pos_next;
  logic [63:0] word;
  logic        is_last;
  logic [63:0] h;
  logic [1:0]  mix_idx;
  logic        mul_done;
  logic [63:0] mul_prod;
  logic        accept;
  logic        emit_go;
  logic        digest_valid;
  logic [63:0] digest_hash;

  assign accept        = message.valid && message.ready;
  assign emit_go       = !digest_valid || digest.ready;
  assign lane_pos_next = lane_pos + 2'd1;

  assign digest.valid      = digest_valid;
  assign digest.hash_value = digest_hash;

  flsh_mul64 u_mul (
    .clk     (clk),
    .rst     (rst),
    .req     (mul_req),
    .done    (mul_done),
    .product (mul_prod)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      flsh_pkg::ST_IDLE: begin
        if (accept) begin
          if (message.last_word && message.byte_count == 4'd0 && lane_pos == 2'd0) begin
            state_next = flsh_pkg::ST_COMBINE;
          end else begin
            state_next = flsh_pkg::ST_W_START;
          end
        end
      end
      flsh_pkg::ST_W_START: state_next = flsh_pkg::ST_W_WAIT;
      flsh_pkg::ST_W_WAIT: begin
        if (mul_done) begin
          state_next = flsh_pkg::ST_V_START;
        end
      end
      flsh_pkg::ST_V_START: state_next = flsh_pkg::ST_V_WAIT;
      flsh_pkg::ST_V_WAIT: begin
        if (mul_done) begin
          priority if (!is_last) begin
            state_next = flsh_pkg::ST_IDLE;
          end else if (lane_pos_next != 2'd0) begin
            state_next = flsh_pkg::ST_W_START;
          end else begin
            state_next = flsh_pkg::ST_COMBINE;
          end
        end
      end
      flsh_pkg::ST_COMBINE: state_next = flsh_pkg::ST_MIX_START;
      flsh_pkg::ST_MIX_START: state_next = flsh_pkg::ST_MIX_WAIT;
      flsh_pkg::ST_MIX_WAIT: begin
        if (mul_done) begin
          if (mix_idx == flsh_pkg::MIX_LAST) begin
            state_next = flsh_pkg::ST_EMIT;
          end else begin
            state_next = flsh_pkg::ST_MIX_START;
          end
        end
      end
      flsh_pkg::ST_EMIT: begin
        if (emit_go) begin
          state_next = flsh_pkg::ST_IDLE;
        end
      end
      default: state_next = flsh_pkg::ST_IDLE;
    endcase
  end

  // outputs: handshake and multiplier requests
  always_comb begin
    message.ready = 1'b0;
    mul_req.start = 1'b0;
    mul_req.a     = word;
    mul_req.b     = flsh_pkg::P2;
    unique case (state)
      flsh_pkg::ST_IDLE: message.ready = 1'b1;
      flsh_pkg::ST_W_START: begin
        mul_req.start = 1'b1;
      end
      flsh_pkg::ST_V_START: begin
        mul_req.start = 1'b1;
        mul_req.a     = (lane_acc[0] + mul_prod) >> flsh_pkg::ROUND_SHIFT;
        mul_req.b     = flsh_pkg::P1;
      end
      flsh_pkg::ST_MIX_START: begin
        mul_req.start = 1'b1;
        mul_req.a     = flsh_pkg::mix_operand(h, lane_acc[0], mix_idx);
        mul_req.b     = flsh_pkg::mix_mult(mix_idx);
      end
      default: begin
        message.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= flsh_pkg::ST_IDLE;
      lane_acc[0]  <= flsh_pkg::SEED0;
      lane_acc[1]  <= flsh_pkg::SEED1;
      lane_acc[2]  <= flsh_pkg::SEED2;
      lane_acc[3]  <= flsh_pkg::SEED3;
      lane_pos     <= 2'd0;
      is_last      <= 1'b0;
      mix_idx      <= flsh_pkg::MIX_FIRST;
      digest_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == flsh_pkg::ST_EMIT && emit_go) begin
        digest_valid <= 1'b1;
        digest_hash  <= h;
      end else if (digest_valid && digest.ready) begin
        digest_valid <= 1'b0;
      end
      unique case (state)
        flsh_pkg::ST_IDLE: begin
          if (accept) begin
            is_last <= message.last_word;
            if (message.last_word) begin
              // the last word keeps only its counted bytes; an empty one becomes a zero word
              word <= flsh_pkg::mask_word(message.data_word, message.byte_count);
            end else begin
              word <= message.data_word;
            end
          end
        end
        flsh_pkg::ST_V_WAIT: begin
          if (mul_done) begin
            // lanes rotate so the lane in work always sits at the front
            lane_acc[0] <= lane_acc[1];
            lane_acc[1] <= lane_acc[2];
            lane_acc[2] <= lane_acc[3];
            lane_acc[3] <= mul_prod;
            lane_pos    <= lane_pos_next;
            word        <= 64'd0;
          end
        end
        flsh_pkg::ST_COMBINE: begin
          h       <= (lane_acc[0] << 1) + (lane_acc[1] << 7)
                   + (lane_acc[2] << 12) + (lane_acc[3] << 18);
          mix_idx <= flsh_pkg::MIX_FIRST;
        end
        flsh_pkg::ST_MIX_WAIT: begin
          if (mul_done) begin
            h           <= mul_prod + flsh_pkg::mix_add(mix_idx);
            mix_idx     <= mix_idx + 2'd1;
            lane_acc[0] <= lane_acc[1];
            lane_acc[1] <= lane_acc[2];
            lane_acc[2] <= lane_acc[3];
            lane_acc[3] <= lane_acc[0];
          end
        end
        flsh_pkg::ST_EMIT: begin
          if (emit_go) begin
            lane_acc[0]  <= flsh_pkg::SEED0;
            lane_acc[1]  <= flsh_pkg::SEED1;
            lane_acc[2]  <= flsh_pkg::SEED2;
            lane_acc[3]  <= flsh_pkg::SEED3;
            lane_pos     <= 2'd0;
          end
        end
        default: begin
          is_last <= is_last;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/flsh_digest_checker.sv -----
// ----------------------------------------------------------------------------
// flsh_digest_checker: digest predictor and comparator for the stripe hash
// Watches both channels. Keeps its own lane accumulators and computes the
// hash that each message should give. Compares every digest request with the
// oldest hash still due and reports mismatches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module flsh_digest_checker (
  input  logic        clk,
  input  logic        rst,
  flsh_word_if        message,
  flsh_hash_if        digest,
  output int unsigned mismatches,
  output int unsigned digests_due
);

  logic [63:0] lanes [4];
  logic [1:0]  next_lane;
  logic [63:0] due_hashes [$];

  function automatic logic [63:0] lane_round(input logic [63:0] v, input logic [63:0] w);
    logic [63:0] t;
    t = v + w * flsh_pkg::P2;
    t = t >> flsh_pkg::ROUND_SHIFT;
    return t * flsh_pkg::P1;
  endfunction

  function automatic logic [63:0] hash_of_lanes();
    logic [63:0] h;
    h = (lanes[0] << 1) + (lanes[1] << 7) + (lanes[2] << 12) + (lanes[3] << 18);
    h = ((h ^ (lanes[0] >> flsh_pkg::MIX0_SHIFT)) * flsh_pkg::P2) + flsh_pkg::P3;
    h = ((h ^ (lanes[1] >> flsh_pkg::MIX1_SHIFT)) * flsh_pkg::P3) + flsh_pkg::P4;
    h = ((h ^ (lanes[2] >> flsh_pkg::MIX2_SHIFT)) * flsh_pkg::P4) + flsh_pkg::P5;
    return h;
  endfunction

  task automatic reseed_lanes();
    lanes[0]  = flsh_pkg::SEED0;
    lanes[1]  = flsh_pkg::SEED1;
    lanes[2]  = flsh_pkg::SEED2;
    lanes[3]  = flsh_pkg::SEED3;
    next_lane = 2'd0;
  endtask

  task automatic absorb_word(input logic [63:0] w);
    lanes[next_lane] = lane_round(lanes[next_lane], w);
    next_lane        = next_lane + 2'd1;
  endtask

  always @(posedge clk) begin
    logic [63:0] word;
    logic [63:0] want;
    logic [3:0]  cnt;
    if (rst) begin
      reseed_lanes();
      due_hashes.delete();
      mismatches  <= 0;
      digests_due <= 0;
    end else begin
      // a digest taken at this edge belongs to an earlier message
      if (digest.valid && digest.ready) begin
        if (due_hashes.size() == 0) begin
          $error("hash_value: no hash due, actual %h", digest.hash_value);
          mismatches <= mismatches + 1;
        end else begin
          want = due_hashes.pop_front();
          if (digest.hash_value !== want) begin
            $error("hash_value: expected %h, actual %h", want, digest.hash_value);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (message.valid && message.ready) begin
        word = message.data_word;
        cnt  = message.byte_count;
        if (!message.last_word) begin
          absorb_word(word);
        end else begin
          if (cnt > 4'd8) begin
            cnt = 4'd8;
          end
          if (cnt != 4'd0) begin
            if (cnt < 4'd8) begin
              word &= (64'd1 << (8 * cnt)) - 64'd1;
            end
            absorb_word(word);
          end
          // pad the open stripe with zero rounds
          while (next_lane != 2'd0) begin
            absorb_word(64'd0);
          end
          due_hashes.push_back(hash_of_lanes());
          reseed_lanes();
        end
      end
      digests_due <= due_hashes.size();
    end
  end

endmodule

// ----- tb/sv/four_lane_stripe_hash64_core_tb.sv -----
// ----------------------------------------------------------------------------
// four_lane_stripe_hash64_core_tb: stripe hash core testbench
// Sends directed and random messages word by word with random gaps on both
// channels. The checker predicts every digest and counts mismatches; this
// module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module four_lane_stripe_hash64_core_tb;

  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned WORD_TARGET = 1150;

  logic        clk;
  logic        rst;
  logic        steady;
  int unsigned mismatches;
  int unsigned digests_due;
  int unsigned quiet_cycles = 0;
  int unsigned words_sent = 0;

  flsh_word_if message_ch ();
  flsh_hash_if digest_ch ();

  four_lane_stripe_hash64_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .message (message_ch),
    .digest  (digest_ch)
  );

  flsh_digest_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .message     (message_ch),
    .digest      (digest_ch),
    .mismatches  (mismatches),
    .digests_due (digests_due)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // digest side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      digest_ch.ready <= 1'b0;
    end else begin
      digest_ch.ready <= steady || ($urandom_range(99) >= 38);
    end
  end

  always @(posedge clk) begin
    if ((message_ch.valid && message_ch.ready) || (digest_ch.valid && digest_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $error("watchdog: no request for %0d cycles", quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic [63:0] w, input logic [3:0] cnt, input logic last);
    while (!steady && $urandom_range(99) < 38) begin
      message_ch.valid <= 1'b0;
      @(posedge clk);
    end
    message_ch.valid      <= 1'b1;
    message_ch.data_word  <= w;
    message_ch.byte_count <= cnt;
    message_ch.last_word  <= last;
    do @(posedge clk); while (!message_ch.ready);
    words_sent++;
  endtask

  // hold the sender until every due hash has come back
  task automatic drain();
    message_ch.valid <= 1'b0;
    do @(posedge clk); while (digests_due != 0);
  endtask

  function automatic logic [63:0] random_word();
    int unsigned pick;
    pick = $urandom_range(15);
    if (pick == 0) begin
      return '0;
    end else if (pick == 1) begin
      return '1;
    end
    return {$urandom, $urandom};
  endfunction

  task automatic send_message(input int unsigned n_words);
    logic [3:0]  cnt;
    int unsigned pick;
    for (int unsigned i = 0; i < n_words; i++) begin
      cnt = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'd8;
      send_word(random_word(), cnt, 1'b0);
    end
    pick = $urandom_range(99);
    if (pick < 10) begin
      cnt = 4'd0;
    end else if (pick < 20) begin
      cnt = 4'($urandom_range(15, 9));
    end else if (pick < 55) begin
      cnt = 4'd8;
    end else begin
      cnt = 4'($urandom_range(7, 1));
    end
    send_word(random_word(), cnt, 1'b1);
  endtask

  initial begin
    int unsigned n_words;
    rst                   <= 1'b1;
    steady                <= 1'b0;
    message_ch.valid      <= 1'b0;
    message_ch.data_word  <= '0;
    message_ch.byte_count <= '0;
    message_ch.last_word  <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty message hashes the seeds
    send_word('0, 4'd0, 1'b1);
    send_word('1, 4'd8, 1'b1);
    // count on a middle word is ignored; four words close the stripe
    send_word('0, 4'd8, 1'b0);
    send_word('1, 4'd0, 1'b0);
    send_word(64'h0123456789abcdef, 4'd15, 1'b0);
    send_word(64'hfedcba9876543210, 4'd8, 1'b1);
    // counts above eight saturate
    send_word('1, 4'd15, 1'b1);
    send_word('1, 4'd9, 1'b1);
    for (int c = 1; c < 8; c++) begin
      send_word('1, 4'(c), 1'b1);
    end
    // closed stripe, then an empty last word: no padding
    for (int i = 0; i < 4; i++) begin
      send_word({$urandom, $urandom}, 4'd8, 1'b0);
    end
    send_word('1, 4'd0, 1'b1);
    // empty last word with two lanes left open
    send_word({$urandom, $urandom}, 4'd8, 1'b0);
    send_word({$urandom, $urandom}, 4'd8, 1'b0);
    send_word('1, 4'd0, 1'b1);
    drain();

    while (words_sent < WORD_TARGET) begin
      steady <= (words_sent >= 450) && (words_sent < 650);
      n_words = ($urandom_range(19) == 0) ? $urandom_range(64, 24) : $urandom_range(9);
      send_message(n_words);
      if ($urandom_range(7) == 0) begin
        drain();
      end
    end
    drain();
    repeat (64) @(posedge clk);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- four_lane_stripe_hash64_core.f -----
sv/flsh_pkg.sv
sv/flsh_if.sv
sv/flsh_mul64.sv
sv/four_lane_stripe_hash64_core.sv
tb/sv/flsh_digest_checker.sv
tb/sv/four_lane_stripe_hash64_core_tb.sv
